### sv/rft3_pkg.sv
// Shared types and constants for the range-filtered top-three select unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rft3_pkg;

  localparam int AGE_W   = 31;
  localparam int SKILL_W = 31;
  localparam int ID_W    = 11;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // One stored record as held in the table memory.
  typedef struct packed {
    logic [SKILL_W-1:0] skill;
    logic [AGE_W-1:0]   age;
  } rec_t;

  // Control from the scan sequencer to the ranking slots.
  typedef struct packed {
    logic clear;
    logic load;
  } rank_ctl_t;

endpackage

`default_nettype wire

### sv/rft3_req_if.sv
// Request channel of the select unit: a valid/ready beat carrying a command.
// Depends on rft3_pkg for the field widths.
`default_nettype none

interface rft3_req_if import rft3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [AGE_W-1:0]   rec_age;
  logic [SKILL_W-1:0] rec_skill;
  logic [AGE_W-1:0]   min_age;
  logic [AGE_W-1:0]   max_age;

  modport source (
    output valid, command, rec_age, rec_skill, min_age, max_age,
    input  ready
  );

  modport sink (
    input  valid, command, rec_age, rec_skill, min_age, max_age,
    output ready
  );
endinterface

`default_nettype wire

### sv/rft3_rsp_if.sv
// Response channel of the select unit: one beat per query with three ids.
// Depends on rft3_pkg for the field widths.
`default_nettype none

interface rft3_rsp_if import rft3_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found_three;
  logic [ID_W-1:0] first_id;
  logic [ID_W-1:0] second_id;
  logic [ID_W-1:0] third_id;
  logic            table_full;

  modport source (
    output valid, found_three, first_id, second_id, third_id, table_full,
    input  ready
  );

  modport sink (
    input  valid, found_three, first_id, second_id, third_id, table_full,
    output ready
  );
endinterface

`default_nettype wire

### sv/rft3_rank.sv
// Three ranking slots with the shared insertion compare of the select unit.
// Depends on rft3_pkg for the record and control types.
`default_nettype none

module rft3_rank import rft3_pkg::*; #(
  parameter int IW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  rank_ctl_t     ctl,
  input  rec_t          cand,
  input  logic [IW-1:0] cand_id,
  output logic [2:0]    slot_val,
  output logic [IW-1:0] slot_id [3]
);

  rec_t       slot_rec [3];
  logic [2:0] win;

  // A candidate beats a slot on higher skill, then on lower age; records arrive
  // in id order, so an exact tie keeps the earlier record in front.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win[k] = !slot_val[k] ||
               ({cand.skill, ~cand.age} > {slot_rec[k].skill, ~slot_rec[k].age});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_val <= '0;
    end else if (ctl.clear) begin
      slot_val <= '0;
    end else if (ctl.load) begin
      if (win[0]) begin
        slot_val <= {slot_val[1], slot_val[0], 1'b1};
      end else if (win[1]) begin
        slot_val <= {slot_val[1], 1'b1, slot_val[0]};
      end else if (win[2]) begin
        slot_val <= {1'b1, slot_val[1], slot_val[0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && !ctl.clear) begin
      if (win[0]) begin
        slot_rec[2] <= slot_rec[1];
        slot_id[2]  <= slot_id[1];
        slot_rec[1] <= slot_rec[0];
        slot_id[1]  <= slot_id[0];
        slot_rec[0] <= cand;
        slot_id[0]  <= cand_id;
      end else if (win[1]) begin
        slot_rec[2] <= slot_rec[1];
        slot_id[2]  <= slot_id[1];
        slot_rec[1] <= cand;
        slot_id[1]  <= cand_id;
      end else if (win[2]) begin
        slot_rec[2] <= cand;
        slot_id[2]  <= cand_id;
      end
    end
  end

endmodule

`default_nettype wire

### sv/range_filtered_top3_select_unit.sv
// Top level of the range-filtered top-three select unit: record table, scan
// sequencer and response register. Depends on rft3_pkg, rft3_req_if,
// rft3_rsp_if and rft3_rank.
`default_nettype none

// Clear and load commands give no response. A query scans the table once, one
// record per cycle through the single read port of the record memory and the
// shared ranking compare. The request side is not ready from the query beat
// until the response register is loaded. It waits longer while the previous
// response beat has not yet been taken. Record ids count from one in load
// order and are reported in eleven bits; a slot that found no record reports
// id zero. No clearing pass is needed after reset.
module range_filtered_top3_select_unit import rft3_pkg::*; #(
  parameter int MAX_RECORDS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  rft3_req_if.sink   req,
  rft3_rsp_if.source rsp
);

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  rec_t             mem [MAX_RECORDS];
  logic [CW-1:0]    count;
  logic             overflow;
  logic [AGE_W-1:0] lo;
  logic [AGE_W-1:0] hi;

  logic [CW-1:0]    scan_addr;
  logic             p1_valid;
  logic [CW-1:0]    p1_id;
  rec_t             rd_rec;
  logic             p2_valid;
  logic [CW-1:0]    p2_id;
  rec_t             p2_rec;

  logic             accept;
  logic             has_room;
  logic             issuing;
  logic             scan_done;
  logic             qualify;
  logic             rsp_free;

  rank_ctl_t        rank_ctl;
  logic [2:0]       slot_val;
  logic [CW-1:0]    slot_id [3];

  logic             rsp_valid;
  logic             out_found;
  logic [ID_W-1:0]  out_first;
  logic [ID_W-1:0]  out_second;
  logic [ID_W-1:0]  out_third;
  logic             out_full;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign has_room  = (count < CW'(MAX_RECORDS));
  assign issuing   = (state == S_SCAN) && (scan_addr < count);
  assign scan_done = !issuing && !p1_valid && !p2_valid;
  assign qualify   = (rd_rec.skill != '0) && (rd_rec.age >= lo) && (rd_rec.age <= hi);
  assign rsp_free  = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (accept && (req.command == CMD_LOAD) && has_room) begin
      mem[count[AW-1:0]] <= '{skill: req.rec_skill, age: req.rec_age};
    end
    rd_rec <= mem[scan_addr[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (req.command == CMD_QUERY)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= issuing;
      p2_valid <= p1_valid && qualify;
      if (accept) begin
        case (req.command)
          CMD_CLEAR: begin
            count    <= '0;
            overflow <= 1'b0;
          end
          CMD_LOAD: begin
            if (has_room) begin
              count <= count + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if ((state == S_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.command == CMD_QUERY)) begin
      lo        <= req.min_age;
      hi        <= req.max_age;
      scan_addr <= '0;
    end else if (issuing) begin
      scan_addr <= scan_addr + 1'b1;
    end
    p1_id  <= scan_addr + 1'b1;
    p2_id  <= p1_id;
    p2_rec <= rd_rec;
    if ((state == S_DONE) && rsp_free) begin
      out_found  <= &slot_val;
      out_first  <= slot_val[0] ? ID_W'(slot_id[0]) : '0;
      out_second <= slot_val[1] ? ID_W'(slot_id[1]) : '0;
      out_third  <= slot_val[2] ? ID_W'(slot_id[2]) : '0;
      out_full   <= overflow;
    end
  end

  assign rank_ctl.clear = accept && (req.command == CMD_QUERY);
  assign rank_ctl.load  = p2_valid;

  rft3_rank #(
    .IW (CW)
  ) u_rank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rank_ctl),
    .cand     (p2_rec),
    .cand_id  (p2_id),
    .slot_val (slot_val),
    .slot_id  (slot_id)
  );

  assign rsp.valid       = rsp_valid;
  assign rsp.found_three = out_found;
  assign rsp.first_id    = out_first;
  assign rsp.second_id   = out_second;
  assign rsp.third_id    = out_third;
  assign rsp.table_full  = out_full;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECORDS))
    else $error("record count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_addr <= count))
    else $error("scan address ran past the stored records");

  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    (!slot_val[1] || slot_val[0]) && (!slot_val[2] || slot_val[1]))
    else $error("ranking slots filled out of order");

  a_query_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.command == CMD_QUERY)) |=> (state == S_SCAN) && !p2_valid)
    else $error("query did not start a fresh scan");
`endif

endmodule

`default_nettype wire

### sim/range_filtered_top3_select_unit_test.sv
// Self-checking testbench for range_filtered_top3_select_unit: a directed table, then
// random record tables and range queries, checked beat by beat against a local ranking model.
// Depends on rft3_pkg, rft3_req_if, rft3_rsp_if and the unit itself.
`timescale 1ns / 1ps

module range_filtered_top3_select_unit_test;
  import rft3_pkg::*;

  localparam int                 CLK_PERIOD  = 10;
  localparam int unsigned        MAX_RECORDS = 1024;
  localparam int unsigned        STALL_LIMIT = 10000;
  localparam int unsigned        HOLD_CYCLES = 400;
  localparam logic [1:0]         CMD_SPARE   = 2'd3;
  localparam logic [AGE_W-1:0]   MAX_FIELD   = '1;

  typedef struct packed {
    logic [1:0]         command;
    logic [AGE_W-1:0]   rec_age;
    logic [SKILL_W-1:0] rec_skill;
    logic [AGE_W-1:0]   min_age;
    logic [AGE_W-1:0]   max_age;
  } req_beat_t;

  typedef struct packed {
    logic            found_three;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
    logic [ID_W-1:0] third_id;
    logic            table_full;
  } answer_t;

  typedef struct packed {
    req_beat_t stim;
    logic      typed;
    answer_t   answer;
  } opening_row_t;

  localparam answer_t NO_IDS   = '{1'b0, 11'd0, 11'd0, 11'd0, 1'b0};
  localparam answer_t ONLY_TWO = '{1'b0, 11'd2, 11'd0, 11'd0, 1'b0};

  localparam int NUM_OPENING = 23;
  localparam opening_row_t OPENING [NUM_OPENING] = '{
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd0, MAX_FIELD}, 1'b1, NO_IDS},
    '{'{CMD_SPARE, MAX_FIELD, MAX_FIELD, MAX_FIELD, MAX_FIELD}, 1'b0, NO_IDS},
    '{'{CMD_LOAD, 31'd0, 31'd0, 31'd0, 31'd0}, 1'b0, NO_IDS},
    '{'{CMD_LOAD, MAX_FIELD, MAX_FIELD, 31'd0, 31'd0}, 1'b0, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd0, MAX_FIELD}, 1'b1, ONLY_TWO},
    '{'{CMD_LOAD, 31'd5, 31'd100, 31'd0, 31'd0}, 1'b0, NO_IDS},
    '{'{CMD_LOAD, 31'd5, 31'd100, 31'd0, 31'd0}, 1'b0, NO_IDS},
    '{'{CMD_LOAD, 31'd3, 31'd100, 31'd0, 31'd0}, 1'b0, NO_IDS},
    '{'{CMD_LOAD, 31'd9, 31'd200, 31'd0, 31'd0}, 1'b0, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd0, MAX_FIELD}, 1'b0, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd4, 31'd8}, 1'b0, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd9, 31'd3}, 1'b1, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd10, 31'd20}, 1'b1, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, MAX_FIELD, MAX_FIELD}, 1'b1, ONLY_TWO},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd0, 31'd0}, 1'b1, NO_IDS},
    '{'{CMD_LOAD, 31'd1, 31'd1, MAX_FIELD, MAX_FIELD}, 1'b0, NO_IDS},
    '{'{CMD_QUERY, MAX_FIELD, MAX_FIELD, 31'd1, MAX_FIELD}, 1'b0, NO_IDS},
    '{'{CMD_SPARE, 31'd0, 31'd0, 31'd0, 31'd0}, 1'b0, NO_IDS},
    '{'{CMD_CLEAR, MAX_FIELD, MAX_FIELD, MAX_FIELD, MAX_FIELD}, 1'b0, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd0, MAX_FIELD}, 1'b1, NO_IDS},
    '{'{CMD_LOAD, MAX_FIELD, 31'd1, 31'd0, 31'd0}, 1'b0, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd0, MAX_FIELD - 31'd1}, 1'b1, NO_IDS},
    '{'{CMD_QUERY, 31'd0, 31'd0, 31'd0, MAX_FIELD}, 1'b0, NO_IDS}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  rft3_req_if req ();
  rft3_rsp_if rsp ();

  range_filtered_top3_select_unit #(
    .MAX_RECORDS(MAX_RECORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [AGE_W-1:0]   age_tab   [MAX_RECORDS];
  logic [SKILL_W-1:0] skill_tab [MAX_RECORDS];
  int unsigned        stored_count = 0;
  logic               dropped_load = 1'b0;

  answer_t     pending_answers [$];
  int unsigned mismatch_count = 0;
  int unsigned beats_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned sink_idle_pct  = 0;
  bit          hold_pending   = 1'b0;

  function automatic logic [AGE_W-1:0] any_value();
    return AGE_W'($urandom());
  endfunction

  function automatic logic [AGE_W-1:0] near(input logic [AGE_W-1:0] base,
                                            input int unsigned span);
    logic [AGE_W:0] v;
    v = {1'b0, base} + (AGE_W + 1)'($urandom_range(span));
    return v[AGE_W] ? MAX_FIELD : v[AGE_W-1:0];
  endfunction

  function automatic req_beat_t make_beat(input logic [1:0] command,
                                          input logic [AGE_W-1:0] rec_age,
                                          input logic [SKILL_W-1:0] rec_skill,
                                          input logic [AGE_W-1:0] min_age,
                                          input logic [AGE_W-1:0] max_age);
    req_beat_t b;
    b.command   = command;
    b.rec_age   = rec_age;
    b.rec_skill = rec_skill;
    b.min_age   = min_age;
    b.max_age   = max_age;
    return b;
  endfunction

  // Scans the stored records in id order, keeping the three best by skill, then age, then id.
  function automatic answer_t rank_query(input logic [AGE_W-1:0] lo, input logic [AGE_W-1:0] hi);
    answer_t            ans;
    int unsigned        top_id    [3];
    logic [SKILL_W-1:0] top_skill [3];
    logic [AGE_W-1:0]   top_age   [3];
    logic [AGE_W-1:0]   a;
    logic [SKILL_W-1:0] s;
    int unsigned        r;
    int                 k, m;
    for (k = 0; k < 3; k++) begin
      top_id[k]    = 0;
      top_skill[k] = '0;
      top_age[k]   = '0;
    end
    for (r = 0; r < stored_count; r++) begin
      a = age_tab[r];
      s = skill_tab[r];
      if (s != '0 && a >= lo && a <= hi) begin
        for (k = 0; k < 3; k++) begin
          if (top_id[k] == 0 || ((s != top_skill[k]) ? (s > top_skill[k]) : (a < top_age[k]))) begin
            for (m = 2; m > k; m--) begin
              top_id[m]    = top_id[m-1];
              top_skill[m] = top_skill[m-1];
              top_age[m]   = top_age[m-1];
            end
            top_id[k]    = r + 1;
            top_skill[k] = s;
            top_age[k]   = a;
            break;
          end
        end
      end
    end
    ans.found_three = (top_id[2] != 0);
    ans.first_id    = ID_W'(top_id[0]);
    ans.second_id   = ID_W'(top_id[1]);
    ans.third_id    = ID_W'(top_id[2]);
    ans.table_full  = dropped_load;
    return ans;
  endfunction

  function automatic bit apply_beat(input req_beat_t b, output answer_t ans);
    ans = NO_IDS;
    apply_beat = 1'b0;
    case (b.command)
      CMD_CLEAR: begin
        stored_count = 0;
        dropped_load = 1'b0;
      end
      CMD_LOAD: begin
        if (stored_count < MAX_RECORDS) begin
          age_tab[stored_count]   = b.rec_age;
          skill_tab[stored_count] = b.rec_skill;
          stored_count++;
        end else begin
          dropped_load = 1'b1;
        end
      end
      CMD_QUERY: begin
        ans = rank_query(b.min_age, b.max_age);
        apply_beat = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send(input req_beat_t b, input logic typed = 1'b0,
                      input answer_t typed_ans = NO_IDS);
    answer_t ans;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.command   <= b.command;
    req.rec_age   <= b.rec_age;
    req.rec_skill <= b.rec_skill;
    req.min_age   <= b.min_age;
    req.max_age   <= b.max_age;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    if (apply_beat(b, ans)) pending_answers.push_back(typed ? typed_ans : ans);
    if (b.command != CMD_SPARE) beats_sent++;
  endtask

  task automatic wait_for_answers();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic play_table(input int unsigned n_loads, input int unsigned n_queries);
    logic [AGE_W-1:0]   base, lo, hi;
    logic [SKILL_W-1:0] skill;
    int unsigned        span, i;
    base = ($urandom_range(3) == 0) ? any_value() : AGE_W'($urandom_range(40));
    span = $urandom_range(12, 1);
    if (stored_count > 400 || $urandom_range(4) != 0)
      send(make_beat(CMD_CLEAR, any_value(), any_value(), any_value(), any_value()));
    for (i = 0; i < n_loads; i++) begin
      if ($urandom_range(19) == 0)
        send(make_beat(CMD_SPARE, any_value(), any_value(), any_value(), any_value()));
      case ($urandom_range(9))
        0:       skill = '0;
        1:       skill = any_value();
        default: skill = SKILL_W'($urandom_range(5, 1));
      endcase
      send(make_beat(CMD_LOAD, near(base, span), skill, any_value(), any_value()));
    end
    for (i = 0; i < n_queries; i++) begin
      case ($urandom_range(7))
        0: begin
          lo = '0;
          hi = MAX_FIELD;
        end
        1: begin
          lo = any_value();
          hi = any_value();
        end
        2: begin
          hi = near(base, span);
          lo = (hi == MAX_FIELD) ? hi : hi + 1'b1;
        end
        default: begin
          lo = near(base, span);
          hi = near(lo, span);
        end
      endcase
      send(make_beat(CMD_QUERY, any_value(), any_value(), lo, hi));
    end
  endtask

  task automatic random_phase(input int unsigned n_beats);
    int unsigned stop_at;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at)
      play_table(($urandom_range(7) == 0) ? $urandom_range(40, 11) : $urandom_range(10),
                 $urandom_range(4, 1));
  endtask

  task automatic check_field(input string field, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $error("response beat with no query outstanding");
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        check_field("found_three", want.found_three, rsp.found_three);
        check_field("first_id", want.first_id, rsp.first_id);
        check_field("second_id", want.second_id, rsp.second_id);
        check_field("third_id", want.third_id, rsp.third_id);
        check_field("table_full", want.table_full, rsp.table_full);
      end
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid === 1'b1 && req.ready === 1'b1) || (rsp.valid === 1'b1 && rsp.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $error("no beat accepted for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int unsigned i;
    req.valid     = 1'b0;
    req.command   = CMD_CLEAR;
    req.rec_age   = '0;
    req.rec_skill = '0;
    req.min_age   = '0;
    req.max_age   = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_OPENING; i++)
      send(OPENING[i].stim, OPENING[i].typed, OPENING[i].answer);
    wait_for_answers();

    send_idle_pct = 30;
    sink_idle_pct = 47;
    random_phase(190);
    wait_for_answers();

    send_idle_pct = 47;
    sink_idle_pct = 30;
    random_phase(190);
    wait_for_answers();

    send_idle_pct = 0;
    sink_idle_pct = 0;
    hold_pending  = 1'b1;
    random_phase(200);
    wait_for_answers();

    repeat (MAX_RECORDS + 8) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d query results never arrived", pending_answers.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
